// ===== hdl/nirt_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the infrared frame transmitter
package nirt_pkg;

	localparam int FRAME_BITS = 32;
	localparam int BITS_W     = $clog2(FRAME_BITS + 1);
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	localparam logic [7:0]  CARRIER_HALF_RST = 8'd13;
	localparam logic [9:0]  LEADER_BURST_RST = 10'd344;
	localparam logic [13:0] LEADER_SPACE_RST = 14'd4500;
	localparam logic [7:0]  BIT_BURST_RST    = 8'd22;
	localparam logic [11:0] ONE_SPACE_RST    = 12'd1690;
	localparam logic [11:0] ZERO_SPACE_RST   = 12'd560;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		REG_CARRIER_HALF = 3'd0,
		REG_LEADER_BURST = 3'd1,
		REG_LEADER_SPACE = 3'd2,
		REG_BIT_BURST    = 3'd3,
		REG_ONE_SPACE    = 3'd4,
		REG_ZERO_SPACE   = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_LEAD_BURST  = 3'd1,
		PH_LEAD_SPACE  = 3'd2,
		PH_BIT_BURST   = 3'd3,
		PH_BIT_SPACE   = 3'd4,
		PH_STOP_BURST  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0]  carrier_half_ticks;
		logic [9:0]  leader_burst_cycles;
		logic [13:0] leader_space_ticks;
		logic [7:0]  bit_burst_cycles;
		logic [11:0] one_space_ticks;
		logic [11:0] zero_space_ticks;
	} cfg_t;

	typedef struct packed {
		logic ir_level;
		logic busy_res;
		logic start_rejected;
	} result_t;

endpackage

// ===== hdl/nec_ir_frame_transmitter_core.sv =====
`timescale 1ns / 1ps
// Infrared frame transmitter: each transaction is either one time tick or a frame start, and
// each gives exactly one result with the pin level for that tick, the busy flag and a flag for
// a rejected start. One transaction is taken every clock cycle while results are taken; it sits
// in the input register, and the frame state machine updates as it moves into the result
// register, from which its result is presented. While a result waits, the input register can
// still take one more transaction. Timing registers are written over the apb port; the user
// must write them only while idle, as the block itself does not enforce it.
module nec_ir_frame_transmitter_core
	import nirt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic              operation,
	input  logic [7:0]        device_address,
	input  logic [7:0]        command_code,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              ir_level,
	output logic              busy_res,
	output logic              start_rejected,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t       cfg;
	result_t    res;
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] addr_s1, cmd_s1;
	logic       valid_s2;
	result_t    res_s2;
	logic       out_free, step;

	assign out_free   = !valid_s2 || result_ready;
	assign step       = valid_s1 && out_free;
	assign item_ready = !valid_s1 || out_free;

	nirt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nirt_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.op             (op_s1),
		.device_address (addr_s1),
		.command_code   (cmd_s1),
		.cfg            (cfg),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (out_free) begin
				valid_s2 <= step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			op_s1   <= op_t'(operation);
			addr_s1 <= device_address;
			cmd_s1  <= command_code;
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	assign result_valid   = valid_s2;
	assign ir_level       = res_s2.ir_level;
	assign busy_res       = res_s2.busy_res;
	assign start_rejected = res_s2.start_rejected;

endmodule

// ===== hdl/nirt_cfg_regs.sv =====
`timescale 1ns / 1ps
// apb configuration registers of the infrared frame transmitter
module nirt_cfg_regs
	import nirt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.carrier_half_ticks  <= CARRIER_HALF_RST;
			cfg_q.leader_burst_cycles <= LEADER_BURST_RST;
			cfg_q.leader_space_ticks  <= LEADER_SPACE_RST;
			cfg_q.bit_burst_cycles    <= BIT_BURST_RST;
			cfg_q.one_space_ticks     <= ONE_SPACE_RST;
			cfg_q.zero_space_ticks    <= ZERO_SPACE_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_CARRIER_HALF: cfg_q.carrier_half_ticks  <= pwdata[7:0];
				REG_LEADER_BURST: cfg_q.leader_burst_cycles <= pwdata[9:0];
				REG_LEADER_SPACE: cfg_q.leader_space_ticks  <= pwdata[13:0];
				REG_BIT_BURST:    cfg_q.bit_burst_cycles    <= pwdata[7:0];
				REG_ONE_SPACE:    cfg_q.one_space_ticks     <= pwdata[11:0];
				REG_ZERO_SPACE:   cfg_q.zero_space_ticks    <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CARRIER_HALF: prdata = DATA_W'(cfg_q.carrier_half_ticks);
			REG_LEADER_BURST: prdata = DATA_W'(cfg_q.leader_burst_cycles);
			REG_LEADER_SPACE: prdata = DATA_W'(cfg_q.leader_space_ticks);
			REG_BIT_BURST:    prdata = DATA_W'(cfg_q.bit_burst_cycles);
			REG_ONE_SPACE:    prdata = DATA_W'(cfg_q.one_space_ticks);
			REG_ZERO_SPACE:   prdata = DATA_W'(cfg_q.zero_space_ticks);
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== hdl/nirt_engine.sv =====
`timescale 1ns / 1ps
// frame state machine and waveform counters, one transaction per step
module nirt_engine
	import nirt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  op_t        op,
	input  logic [7:0] device_address,
	input  logic [7:0] command_code,
	input  cfg_t       cfg,
	output result_t    res
);

	phase_t            phase_q, phase_d;
	logic [31:0]       frame_q, frame_d;
	logic [BITS_W-1:0] bits_q, bits_d, bits_dec;
	logic [13:0]       space_q, space_d, space_inc, space_lim;
	logic [9:0]        cycle_q, cycle_d, cycle_inc, cycle_lim;
	logic [7:0]        half_q, half_d, half_inc;
	logic              carrier_q, carrier_d;
	logic              busy, is_start, is_tick;
	logic              half_wrap, burst_end, space_end;

	assign busy     = (phase_q != PH_IDLE);
	assign is_start = step && (op == OP_START);
	assign is_tick  = step && (op == OP_TICK);

	// tick helpers
	assign half_inc  = half_q + 8'd1;
	assign half_wrap = !(half_inc < cfg.carrier_half_ticks);
	assign cycle_inc = cycle_q + 10'd1;
	assign cycle_lim = (phase_q == PH_LEAD_BURST) ? cfg.leader_burst_cycles
	                                               : {2'b00, cfg.bit_burst_cycles};
	assign burst_end = half_wrap && !carrier_q && (cycle_inc >= cycle_lim);
	assign space_inc = space_q + 14'd1;
	assign space_lim = (phase_q == PH_LEAD_SPACE) ? cfg.leader_space_ticks
	                 : (frame_q[31] ? {2'b00, cfg.one_space_ticks}
	                                : {2'b00, cfg.zero_space_ticks});
	assign space_end = (space_inc >= space_lim);
	assign bits_dec  = bits_q - BITS_W'(1);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (is_start) begin
			if (!busy) begin
				phase_d = PH_LEAD_BURST;
			end
		end else if (is_tick) begin
			unique case (phase_q)
				PH_LEAD_BURST: if (burst_end) phase_d = PH_LEAD_SPACE;
				PH_LEAD_SPACE: if (space_end) phase_d = PH_BIT_BURST;
				PH_BIT_BURST:  if (burst_end) phase_d = PH_BIT_SPACE;
				PH_BIT_SPACE: begin
					if (space_end) begin
						phase_d = (bits_dec == '0) ? PH_STOP_BURST : PH_BIT_BURST;
					end
				end
				PH_STOP_BURST: if (burst_end) phase_d = PH_IDLE;
				default:       phase_d = PH_IDLE;
			endcase
		end
	end

	// counters, frame and result
	always_comb begin
		frame_d   = frame_q;
		bits_d    = bits_q;
		space_d   = space_q;
		cycle_d   = cycle_q;
		half_d    = half_q;
		carrier_d = carrier_q;
		res.ir_level       = 1'b0;
		res.start_rejected = 1'b0;
		res.busy_res       = (phase_d != PH_IDLE);
		if (is_start) begin
			if (busy) begin
				res.start_rejected = 1'b1;
				res.ir_level       = carrier_q;
			end else begin
				frame_d   = {device_address, ~device_address, command_code, ~command_code};
				bits_d    = '0;
				space_d   = '0;
				cycle_d   = '0;
				half_d    = '0;
				carrier_d = 1'b1;
				res.ir_level = 1'b1;
			end
		end else if (is_tick) begin
			res.ir_level = busy ? carrier_q : 1'b0;
			case (phase_q)
				PH_LEAD_BURST, PH_BIT_BURST, PH_STOP_BURST: begin
					half_d = half_wrap ? 8'd0 : half_inc;
					if (half_wrap) begin
						if (carrier_q) begin
							carrier_d = 1'b0;
						end else begin
							cycle_d   = cycle_inc;
							carrier_d = !burst_end;
						end
					end
					if (burst_end && phase_q != PH_STOP_BURST) begin
						space_d = '0;
					end
				end
				PH_LEAD_SPACE, PH_BIT_SPACE: begin
					space_d = space_inc;
					if (space_end) begin
						if (phase_q == PH_LEAD_SPACE) begin
							bits_d = BITS_W'(FRAME_BITS);
						end else begin
							frame_d = {frame_q[30:0], 1'b0};
							bits_d  = bits_dec;
						end
						carrier_d = 1'b1;
						half_d    = '0;
						cycle_d   = '0;
					end
				end
				default: carrier_d = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			frame_q   <= '0;
			bits_q    <= '0;
			space_q   <= '0;
			cycle_q   <= '0;
			half_q    <= '0;
			carrier_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			frame_q   <= frame_d;
			bits_q    <= bits_d;
			space_q   <= space_d;
			cycle_q   <= cycle_d;
			half_q    <= half_d;
			carrier_q <= carrier_d;
		end
	end

endmodule

// ===== hdl/nirt_checker.sv =====
`timescale 1ns / 1ps
// port checker of the infrared frame transmitter and its bind
module nirt_checker (
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_ready,
	input logic ir_level,
	input logic busy_res,
	input logic start_rejected
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
		$stable(ir_level) && $stable(busy_res) && $stable(start_rejected))
		else $error("stalled result changed");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && start_rejected |-> busy_res)
		else $error("start rejected while idle");

	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !busy_res |-> !ir_level)
		else $error("pin high outside a frame");

endmodule

bind nec_ir_frame_transmitter_core nirt_checker u_nirt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.ir_level       (ir_level),
	.busy_res       (busy_res),
	.start_rejected (start_rejected)
);

// ===== sim/nec_ir_frame_checker.sv =====
`timescale 1ns / 1ps
// frame predictor and result checker for the infrared transmitter, watching every port
module nec_ir_frame_checker
	import nirt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  logic              operation,
	input  logic [7:0]        device_address,
	input  logic [7:0]        command_code,
	input  logic              result_valid,
	input  logic              result_ready,
	input  logic              ir_level,
	input  logic              busy_res,
	input  logic              start_rejected,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic [DATA_W-1:0] prdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending,
	output logic              frame_active
);

	cfg_t        timing;
	phase_t      ph;
	logic [31:0] shift_reg;
	logic [5:0]  bits_todo;
	logic [13:0] space_cnt;
	logic [9:0]  cycle_cnt;
	logic [7:0]  half_cnt;
	logic        carrier;

	result_t     ir_due[$];
	result_t     want;
	logic [31:0] stored;
	int          mismatches = 0;

	assign fail_count = mismatches;

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		$display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
		mismatches++;
	endtask

	function automatic void open_burst(phase_t nxt);
		ph = nxt;
		carrier = 1'b1;
		half_cnt = '0;
		cycle_cnt = '0;
	endfunction

	function automatic void open_space(phase_t nxt);
		ph = nxt;
		carrier = 1'b0;
		space_cnt = '0;
	endfunction

	// one tick of carrier, true once the last cycle of the burst is done
	function automatic logic carrier_step(logic [9:0] cycles);
		half_cnt = half_cnt + 8'd1;
		if (half_cnt < timing.carrier_half_ticks)
			return 1'b0;
		half_cnt = '0;
		if (carrier) begin
			carrier = 1'b0;
			return 1'b0;
		end
		cycle_cnt = cycle_cnt + 10'd1;
		if (cycle_cnt >= cycles) begin
			carrier = 1'b0;
			return 1'b1;
		end
		carrier = 1'b1;
		return 1'b0;
	endfunction

	function automatic logic silence_step(logic [13:0] ticks);
		space_cnt = space_cnt + 14'd1;
		return space_cnt >= ticks;
	endfunction

	function automatic result_t predict_ir(op_t op, logic [7:0] addr, logic [7:0] cmd);
		result_t r;
		logic    active;
		logic    done;
		r = '0;
		active = (ph != PH_IDLE);
		if (op == OP_START) begin
			if (active) begin
				r.start_rejected = 1'b1;
			end else begin
				shift_reg = {addr, ~addr, cmd, ~cmd};
				bits_todo = '0;
				space_cnt = '0;
				open_burst(PH_LEAD_BURST);
			end
			r.ir_level = carrier;
		end else if (active) begin
			r.ir_level = carrier;
			case (ph)
				PH_LEAD_BURST: begin
					if (carrier_step(timing.leader_burst_cycles))
						open_space(PH_LEAD_SPACE);
				end
				PH_LEAD_SPACE: begin
					if (silence_step(timing.leader_space_ticks)) begin
						bits_todo = 6'(FRAME_BITS);
						open_burst(PH_BIT_BURST);
					end
				end
				PH_BIT_BURST: begin
					if (carrier_step(10'(timing.bit_burst_cycles)))
						open_space(PH_BIT_SPACE);
				end
				PH_BIT_SPACE: begin
					if (shift_reg[31])
						done = silence_step(14'(timing.one_space_ticks));
					else
						done = silence_step(14'(timing.zero_space_ticks));
					if (done) begin
						shift_reg = shift_reg << 1;
						bits_todo = bits_todo - 6'd1;
						if (bits_todo == '0)
							open_burst(PH_STOP_BURST);
						else
							open_burst(PH_BIT_BURST);
					end
				end
				PH_STOP_BURST: begin
					if (carrier_step(10'(timing.bit_burst_cycles))) begin
						ph = PH_IDLE;
						carrier = 1'b0;
					end
				end
				default: begin
					ph = PH_IDLE;
					carrier = 1'b0;
				end
			endcase
		end else begin
			ph = PH_IDLE;
			carrier = 1'b0;
			r.ir_level = 1'b0;
		end
		r.busy_res = (ph != PH_IDLE);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing = {CARRIER_HALF_RST, LEADER_BURST_RST, LEADER_SPACE_RST,
				BIT_BURST_RST, ONE_SPACE_RST, ZERO_SPACE_RST};
			ph = PH_IDLE;
			shift_reg = '0;
			bits_todo = '0;
			space_cnt = '0;
			cycle_cnt = '0;
			half_cnt = '0;
			carrier = 1'b0;
			ir_due.delete();
			frame_active <= 1'b0;
			pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (ir_due.size() == 0) begin
					flag_mismatch("result with no transaction outstanding", 32'd1, 32'd0);
				end else begin
					want = ir_due.pop_front();
					if (ir_level !== want.ir_level)
						flag_mismatch("ir_level", ir_level, want.ir_level);
					if (busy_res !== want.busy_res)
						flag_mismatch("busy_res", busy_res, want.busy_res);
					if (start_rejected !== want.start_rejected)
						flag_mismatch("start_rejected", start_rejected, want.start_rejected);
				end
			end
			if (item_valid && item_ready)
				ir_due.push_back(predict_ir(op_t'(operation), device_address, command_code));
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx_t'(paddr[ADDR_W-1:2]))
						REG_CARRIER_HALF: timing.carrier_half_ticks = pwdata[7:0];
						REG_LEADER_BURST: timing.leader_burst_cycles = pwdata[9:0];
						REG_LEADER_SPACE: timing.leader_space_ticks = pwdata[13:0];
						REG_BIT_BURST:    timing.bit_burst_cycles = pwdata[7:0];
						REG_ONE_SPACE:    timing.one_space_ticks = pwdata[11:0];
						REG_ZERO_SPACE:   timing.zero_space_ticks = pwdata[11:0];
						default: ;
					endcase
				end else begin
					case (reg_idx_t'(paddr[ADDR_W-1:2]))
						REG_CARRIER_HALF: stored = 32'(timing.carrier_half_ticks);
						REG_LEADER_BURST: stored = 32'(timing.leader_burst_cycles);
						REG_LEADER_SPACE: stored = 32'(timing.leader_space_ticks);
						REG_BIT_BURST:    stored = 32'(timing.bit_burst_cycles);
						REG_ONE_SPACE:    stored = 32'(timing.one_space_ticks);
						REG_ZERO_SPACE:   stored = 32'(timing.zero_space_ticks);
						default:          stored = prdata;
					endcase
					if (prdata !== stored)
						flag_mismatch("register readback", prdata, stored);
				end
			end
			frame_active <= (ph != PH_IDLE);
			pending <= ir_due.size();
		end
	end

endmodule

// ===== sim/nec_ir_frame_transmitter_core_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the infrared frame transmitter: stimulus, flow control and verdict
module nec_ir_frame_transmitter_core_tb;
	import nirt_pkg::*;

	localparam int FRAME_ITEMS = 800;
	localparam int CYCLE_LIMIT = 400000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	logic              operation = OP_TICK;
	logic [7:0]        device_address = '0;
	logic [7:0]        command_code = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	logic              ir_level;
	logic              busy_res;
	logic              start_rejected;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int   fails;
	int   pending;
	logic frame_active;

	logic calm = 1'b0;
	int   cycles = 0;
	int   transactions = 0;
	int   frame_starts = 0;
	int   settings_loaded = 0;
	int   frame_items = 0;
	cfg_t t;

	nec_ir_frame_transmitter_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.operation      (operation),
		.device_address (device_address),
		.command_code   (command_code),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.ir_level       (ir_level),
		.busy_res       (busy_res),
		.start_rejected (start_rejected),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	nec_ir_frame_checker i_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.operation      (operation),
		.device_address (device_address),
		.command_code   (command_code),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.ir_level       (ir_level),
		.busy_res       (busy_res),
		.start_rejected (start_rejected),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.fail_count     (fails),
		.pending        (pending),
		.frame_active   (frame_active)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stall before each result, none while calm
	initial begin : result_side
		int gap;
		forever begin
			gap = calm ? 0 : $urandom_range(0, 7);
			if (gap != 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic logic [31:0] upper_noise(int width);
		if ($urandom_range(0, 3) == 0)
			return $urandom() << width;
		return '0;
	endfunction

	task automatic send_item(op_t op, logic [7:0] addr, logic [7:0] cmd);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		device_address <= addr;
		command_code <= cmd;
		do @(posedge clk); while (!(item_valid && item_ready));
		transactions++;
		if (op == OP_START)
			frame_starts++;
	endtask

	task automatic apb_access(logic wr, reg_idx_t idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_W'(4 * idx);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic read_back_timing();
		for (int i = REG_CARRIER_HALF; i <= REG_ZERO_SPACE; i++)
			apb_access(1'b0, reg_idx_t'(i), '0);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_timing(cfg_t c);
		apb_access(1'b1, REG_CARRIER_HALF, upper_noise(8) | 32'(c.carrier_half_ticks));
		apb_access(1'b1, REG_LEADER_BURST, upper_noise(10) | 32'(c.leader_burst_cycles));
		apb_access(1'b1, REG_LEADER_SPACE, upper_noise(14) | 32'(c.leader_space_ticks));
		apb_access(1'b1, REG_BIT_BURST, upper_noise(8) | 32'(c.bit_burst_cycles));
		apb_access(1'b1, REG_ONE_SPACE, upper_noise(12) | 32'(c.one_space_ticks));
		apb_access(1'b1, REG_ZERO_SPACE, upper_noise(12) | 32'(c.zero_space_ticks));
		read_back_timing();
		settings_loaded++;
	endtask

	task automatic wait_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// tick until the frame in flight is over, then let every result drain
	task automatic finish_frame();
		do send_item(OP_TICK, 8'($urandom()), 8'($urandom())); while (frame_active);
		wait_results();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, ticks while idle
		read_back_timing();
		send_item(OP_TICK, 8'hFF, 8'hFF);
		send_item(OP_TICK, 8'h00, 8'h00);
		wait_results();

		// zero counts act as one
		t = '0;
		load_timing(t);
		send_item(OP_START, 8'h00, 8'hFF);
		send_item(OP_START, 8'hFF, 8'h00);
		finish_frame();

		t = {8'd1, 10'd1, 14'd1, 8'd1, 12'd1, 12'd1};
		load_timing(t);
		send_item(OP_START, 8'hFF, 8'h00);
		send_item(OP_TICK, 8'h00, 8'h00);
		send_item(OP_START, 8'h5A, 8'hA5);
		finish_frame();

		// random timing and frames, with rejected starts mixed in
		while (frame_items < FRAME_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			t.carrier_half_ticks = 8'($urandom_range(0, 2));
			t.leader_burst_cycles = 10'($urandom_range(0, 4));
			t.leader_space_ticks = 14'($urandom_range(0, 5));
			t.bit_burst_cycles = 8'($urandom_range(0, 2));
			t.one_space_ticks = 12'($urandom_range(0, 4));
			t.zero_space_ticks = 12'($urandom_range(0, 4));
			load_timing(t);
			repeat ($urandom_range(1, 2)) begin
				repeat ($urandom_range(0, 2))
					send_item(OP_TICK, 8'($urandom()), 8'($urandom()));
				send_item(OP_START, pick_byte(), pick_byte());
				do begin
					if ($urandom_range(0, 39) == 0)
						send_item(OP_START, pick_byte(), pick_byte());
					else
						send_item(OP_TICK, 8'($urandom()), 8'($urandom()));
					frame_items++;
				end while (frame_active);
			end
			finish_frame();
		end

		// largest timing values, frame left running at the end
		calm = 1'b0;
		t = {8'd255, 10'd1023, 14'd16383, 8'd255, 12'd4095, 12'd4095};
		load_timing(t);
		send_item(OP_START, 8'hA5, 8'h3C);
		for (int k = 0; k < 600; k++) begin
			if (k == 300)
				send_item(OP_START, 8'h00, 8'hFF);
			else
				send_item(OP_TICK, 8'($urandom()), 8'($urandom()));
		end
		wait_results();
		repeat (10) @(posedge clk);

		$display("ran %0d transactions with %0d frame starts over %0d timing settings",
			transactions, frame_starts, settings_loaded);
		$display("mismatches: %0d", fails);
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
